// File: sv/srr_pkg.sv
// Shared types and constants for the selective-repeat receiver.
package srr_pkg;

	typedef struct packed {
		logic wr;
		logic rd;
	} slot_ctl_t;

	localparam logic       KIND_DELIVER = 1'b0;
	localparam logic       KIND_ACK     = 1'b1;
	localparam int         WIN_W        = 3;
	localparam logic [2:0] WIN_RESET    = 3'd4;
	localparam int         WIN_CAP      = 4;

endpackage

// File: sv/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver top level with window sequencer and result register.
// A packet is accepted, then classified and stored; each in-order word (at most the
// window size) takes a slot read and a result load, a last walk step ends the run, then
// the acknowledgement. Off the window base a packet skips to the acknowledgement; a
// dropped one returns to idle. Results may stall; the input stalls meanwhile. Reset
// clears the window base, filled bits and result valid flag; the window size resets to 4.
module selective_repeat_receiver #(
	parameter int SEQ_BITS      = 3,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_data,
	input  logic                     pkt_valid,
	output logic                     pkt_stall,
	input  logic [SEQ_BITS-1:0]      seq_num,
	input  logic                     checksum_ok,
	input  logic [PAYLOAD_WIDTH-1:0] payload,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic                     kind,
	output logic [PAYLOAD_WIDTH-1:0] deliver_data,
	output logic [SEQ_BITS-1:0]      ack_num,
	output logic                     last
);

	localparam int HALF    = 1 << (SEQ_BITS - 1);
	localparam int WIN_LIM = (HALF < srr_pkg::WIN_CAP) ? HALF : srr_pkg::WIN_CAP;
	localparam int CMP_W   = (SEQ_BITS > srr_pkg::WIN_W) ? SEQ_BITS : srr_pkg::WIN_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_DLV   = 3'd3;
	localparam logic [2:0] S_ACK   = 3'd4;

	logic [2:0]               state_q;
	logic [2:0]               win_q;
	logic [SEQ_BITS-1:0]      base_q;
	logic [2:0]               cnt_q;
	logic [SEQ_BITS-1:0]      seq_q;
	logic                     ok_q;
	logic [PAYLOAD_WIDTH-1:0] data_q;

	logic                     res_valid_q;
	logic                     kind_q;
	logic [PAYLOAD_WIDTH-1:0] deliver_data_q;
	logic [SEQ_BITS-1:0]      ack_num_q;
	logic                     last_q;

	logic [2:0]               w_eff;
	logic [SEQ_BITS-1:0]      off;
	logic [SEQ_BITS-1:0]      prev_base;
	logic [SEQ_BITS-1:0]      prev_off;
	logic                     in_win;
	logic                     in_prev;
	logic                     pkt_take;
	logic                     out_free;
	logic                     walk_go;
	logic                     load_dlv;
	logic                     load_ack;
	srr_pkg::slot_ctl_t       slot_ctl;
	logic [PAYLOAD_WIDTH-1:0] slot_rd_data;
	logic                     slot_rd_filled;

	always_comb begin
		if (win_q == 3'd0) begin
			w_eff = 3'd1;
		end else if (win_q > 3'(WIN_LIM)) begin
			w_eff = 3'(WIN_LIM);
		end else begin
			w_eff = win_q;
		end
	end

	assign off       = seq_q - base_q;
	assign prev_base = base_q - SEQ_BITS'(w_eff);
	assign prev_off  = seq_q - prev_base;
	assign in_win    = CMP_W'(off) < CMP_W'(w_eff);
	assign in_prev   = CMP_W'(prev_off) < CMP_W'(w_eff);

	assign pkt_stall = (state_q != S_IDLE);
	assign pkt_take  = pkt_valid && !pkt_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign walk_go   = (cnt_q < w_eff) && slot_rd_filled;
	assign load_dlv  = (state_q == S_DLV) && out_free;
	assign load_ack  = (state_q == S_ACK) && out_free;

	always_comb begin
		slot_ctl.wr = (state_q == S_CHECK) && ok_q && in_win;
		slot_ctl.rd = (state_q == S_WALK) && walk_go;
	end

	srr_slots #(
		.ADDR_W (SEQ_BITS),
		.DATA_W (PAYLOAD_WIDTH)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (slot_ctl),
		.wr_addr   (seq_q),
		.wr_data   (data_q),
		.rd_addr   (base_q),
		.rd_data   (slot_rd_data),
		.rd_filled (slot_rd_filled)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= srr_pkg::WIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			win_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			seq_q  <= seq_num;
			ok_q   <= checksum_ok;
			data_q <= payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pkt_take) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					cnt_q <= '0;
					if (!ok_q) begin
						state_q <= S_IDLE;
					end else if (in_win) begin
						state_q <= (seq_q == base_q) ? S_WALK : S_ACK;
					end else if (in_prev) begin
						state_q <= S_ACK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WALK: begin
					if (walk_go) begin
						base_q  <= base_q + SEQ_BITS'(1);
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_DLV;
					end else begin
						state_q <= S_ACK;
					end
				end
				S_DLV: begin
					if (out_free) begin
						state_q <= S_WALK;
					end
				end
				S_ACK: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_dlv || load_ack) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_dlv) begin
			kind_q         <= srr_pkg::KIND_DELIVER;
			deliver_data_q <= slot_rd_data;
			ack_num_q      <= '0;
			last_q         <= 1'b0;
		end else if (load_ack) begin
			kind_q         <= srr_pkg::KIND_ACK;
			deliver_data_q <= '0;
			ack_num_q      <= seq_q;
			last_q         <= 1'b1;
		end
	end

	assign res_valid    = res_valid_q;
	assign kind         = kind_q;
	assign deliver_data = deliver_data_q;
	assign ack_num      = ack_num_q;
	assign last         = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_DLV) |-> (cnt_q <= w_eff))
		else $error("delivery count exceeds the window");

	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == srr_pkg::KIND_ACK) |-> last)
		else $error("acknowledgement without last");

	a_dlv_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == srr_pkg::KIND_DELIVER) |-> (!last && ack_num == '0))
		else $error("malformed delivery word");

	a_walk_adv: assert property (@(posedge clk) disable iff (!arst_n)
		slot_ctl.rd |=> (base_q == $past(base_q) + SEQ_BITS'(1)) && (state_q == S_DLV))
		else $error("window base did not advance on delivery");

endmodule

// File: sv/srr_slots.sv
// Receive slot store: payload memory with registered read and per-slot filled bits.
module srr_slots #(
	parameter int ADDR_W = 3,
	parameter int DATA_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srr_pkg::slot_ctl_t   ctl,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  logic [DATA_W-1:0]    wr_data,
	input  logic [ADDR_W-1:0]    rd_addr,
	output logic [DATA_W-1:0]    rd_data,
	output logic                 rd_filled
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  filled_q;
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else begin
			if (ctl.rd) begin
				filled_q[rd_addr] <= 1'b0;
			end
			if (ctl.wr) begin
				filled_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data   = rd_data_q;
	assign rd_filled = filled_q[rd_addr];

endmodule
